>>> src/swm_pkg.sv
package swm_pkg;

	localparam int WINDOW_MAX = 64;
	localparam int IDX_W      = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int CNT_W      = $clog2(WINDOW_MAX + 1) + 1;
	localparam int SAMPLE_W   = 32;
	localparam int MED_W      = SAMPLE_W + 1;
	localparam int CFG_W      = 7;
	localparam int IN_TDATA_W  = ((SAMPLE_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((MED_W + 7) / 8) * 8;

	localparam logic [CFG_W-1:0] WINDOW_SIZE_RESET = CFG_W'(3);

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic [IDX_W-1:0]           age_t;
	typedef logic [CNT_W-1:0]           cnt_t;
	typedef logic signed [MED_W-1:0]    med_t;

	typedef struct packed {
		sample_t sample;
		sample_t old;
		age_t    age_last;
		logic    full;
		logic    en;
	} bcast_t;

	typedef struct packed {
		sample_t val;
		age_t    age;
		logic    up;
		logic    down;
	} cell_link_t;

	localparam cell_link_t LINK_IDLE = '0;

	function automatic cnt_t eff_len(input logic [CFG_W-1:0] ws);
		cnt_t k;
		k = CNT_W'(ws);
		if (k < cnt_t'(1))
			k = cnt_t'(1);
		if (k > cnt_t'(WINDOW_MAX))
			k = cnt_t'(WINDOW_MAX);
		return k;
	endfunction

endpackage

>>> src/swm_cell.sv
module swm_cell import swm_pkg::*; (
	input  logic       clk,
	input  bcast_t     bc,
	input  logic       valid,
	input  cell_link_t lower,
	input  cell_link_t upper,
	output cell_link_t link,
	output sample_t    val,
	output logic       rm
);

	sample_t val_q;
	age_t    age_q;
	logic    kept;
	logic    gt;
	logic    above;
	logic    stay;

	always_comb begin
		rm    = valid & bc.full & (age_q == bc.age_last);
		kept  = valid & ~rm;
		gt    = kept & (val_q > bc.sample);
		above = kept & bc.full & (val_q >= bc.old);
		stay  = kept & (above == gt);
		link.val  = val_q;
		link.age  = age_q;
		link.up   = gt & ~above;
		link.down = above & ~gt;
		val = val_q;
	end

	// take from above on removal, keep the value on stay, from below on insertion, else the new sample
	always_ff @(posedge clk) begin
		if (bc.en) begin
			if (upper.down) begin
				val_q <= upper.val;
				age_q <= age_t'(upper.age + 1'b1);
			end else if (stay) begin
				age_q <= age_t'(age_q + 1'b1);
			end else if (lower.up) begin
				val_q <= lower.val;
				age_q <= age_t'(lower.age + 1'b1);
			end else begin
				val_q <= bc.sample;
				age_q <= '0;
			end
		end
	end

endmodule

>>> src/swm_median.sv
module swm_median import swm_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  sample_t                vals [WINDOW_MAX],
	input  age_t                   lo_idx,
	input  age_t                   hi_idx,
	input  logic                   pending,
	output logic                   adv,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata
);

	logic    valid_q;
	med_t    data_q;
	sample_t lo_val;
	sample_t hi_val;
	med_t    sum;

	always_comb begin
		lo_val = vals[lo_idx];
		hi_val = vals[hi_idx];
		sum    = med_t'(lo_val) + med_t'(hi_val);
		adv    = ~valid_q | m_tready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= pending;
		end
	end

	always_ff @(posedge clk) begin
		if (pending && adv)
			data_q <= sum;
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {{(OUT_TDATA_W - MED_W){1'b0}}, data_q};

endmodule

>>> src/sliding_window_median.sv
// m_tvalid follows the causing transfer through res_s1_q and the median valid register.
// Throughput: one sample per cycle unless the median stage stalls; the sorted cells update
// in parallel on accept; the median stage reads them, holding its result until transferred.
// Reset clears the fill count, the pending flags and sets window_size to 3.
// Cell contents are undefined after reset and are only read once written.
module sliding_window_median import swm_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,  // [31:0] sample
	input  logic                   s_tuser,  // [0] start_new
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,  // [32:0] median_doubled
	input  logic                   cfg_we,
	input  logic [CFG_W-1:0]       cfg_wdata
);

	logic [CFG_W-1:0]      window_size_q;
	cnt_t                  count_q;
	logic                  res_s1_q;
	cnt_t                  k_len;
	cnt_t                  eff_count;
	cnt_t                  k_dec;
	logic                  full;
	logic                  produce;
	logic                  accept;
	logic                  adv;
	bcast_t                bc;
	sample_t               old_val;
	age_t                  lo_idx;
	age_t                  hi_idx;
	logic [WINDOW_MAX-1:0] valid_vec;
	logic [WINDOW_MAX-1:0] rm_vec;
	sample_t               vals  [WINDOW_MAX];
	cell_link_t            links [WINDOW_MAX];

	always_comb begin
		k_len     = eff_len(window_size_q);
		k_dec     = cnt_t'(k_len - 1'b1);
		eff_count = s_tuser ? '0 : count_q;
		full      = eff_count >= k_len;
		produce   = full | (cnt_t'(eff_count + 1'b1) == k_len);
		accept    = s_tvalid & s_tready;
		lo_idx    = k_dec[IDX_W:1];
		hi_idx    = k_len[IDX_W:1];
		old_val   = '0;
		for (int i = 0; i < WINDOW_MAX; i++)
			old_val = old_val | (vals[i] & {SAMPLE_W{rm_vec[i]}});
		bc.sample   = s_tdata[SAMPLE_W-1:0];
		bc.old      = old_val;
		bc.age_last = k_dec[IDX_W-1:0];
		bc.full     = full;
		bc.en       = accept;
	end

	assign s_tready = ~res_s1_q | adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q <= WINDOW_SIZE_RESET;
			count_q       <= '0;
			res_s1_q      <= 1'b0;
		end else begin
			if (cfg_we) begin
				window_size_q <= cfg_wdata;
				count_q       <= '0;
			end else if (accept) begin
				count_q <= full ? eff_count : cnt_t'(eff_count + 1'b1);
			end
			if (accept)
				res_s1_q <= produce;
			else if (adv)
				res_s1_q <= 1'b0;
		end
	end

	for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
		cell_link_t lower;
		cell_link_t upper;

		assign valid_vec[i] = cnt_t'(i) < eff_count;

		if (i == 0) begin : g_first
			assign lower = LINK_IDLE;
		end else begin : g_lower
			assign lower = links[i-1];
		end
		if (i == WINDOW_MAX - 1) begin : g_last
			assign upper = LINK_IDLE;
		end else begin : g_upper
			assign upper = links[i+1];
		end

		swm_cell u_cell (
			.clk   (clk),
			.bc    (bc),
			.valid (valid_vec[i]),
			.lower (lower),
			.upper (upper),
			.link  (links[i]),
			.val   (vals[i]),
			.rm    (rm_vec[i])
		);
	end

	swm_median u_median (
		.clk      (clk),
		.arst_n   (arst_n),
		.vals     (vals),
		.lo_idx   (lo_idx),
		.hi_idx   (hi_idx),
		.pending  (res_s1_q),
		.adv      (adv),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= k_len)
		else $error("fill count beyond window length");

	a_one_removed: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && full) |-> $onehot(rm_vec))
		else $error("sliding transfer must drop exactly one cell");

	a_no_remove_fill: assert property (@(posedge clk) disable iff (!arst_n)
		!full |-> (rm_vec == '0))
		else $error("cell dropped while window is filling");

	a_result_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && produce) |=> res_s1_q)
		else $error("result lost after a completing transfer");

	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(res_s1_q && !adv) |-> !s_tready)
		else $error("sample taken while the median stage is blocked");

endmodule
